// File: design/qds_pkg.sv
// qds_pkg: shared constants, codes and controller/datapath types for the
// queue delay statistics block; no dependencies
package qds_pkg;

    localparam int QUEUE_DEPTH = 128;
    localparam int TIME_BITS   = 32;

    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ACC_W       = 48;
    localparam int QLEN_W      = 8;
    localparam int SERVED_W    = 32;
    localparam int DELAY_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int EVT_TIME_W  = 32;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_FIELD_W = QLEN_W + 1 + SERVED_W + DELAY_W + 3 * ACC_W + STATUS_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int PROD_W      = CNT_W + TIME_BITS;
    localparam int SUM_W       = ((PROD_W > ACC_W) ? PROD_W : ACC_W) + 1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_BACKWARD = 2'd2
    } t_status;

    typedef enum logic {
        OP_ARRIVE = 1'b0,
        OP_DEPART = 1'b1
    } t_op;

    typedef struct packed {
        logic capture;
        logic calc;
        logic apply;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

// File: design/qds_ctrl.sv
// qds_ctrl: event sequencer, capture then calc then apply
// depends on qds_pkg
module qds_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  qds_pkg::t_sts i_sts,
    output qds_pkg::t_cmd o_cmd
);
    import qds_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_APPLY
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ready;
    logic   n_ready;

    always_comb begin
        n_state = r_state;
        n_ready = r_ready;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid && r_ready) begin
                    n_state = S_CALC;
                    n_ready = 1'b0;
                end
            end
            S_CALC: begin
                n_state = S_APPLY;
            end
            S_APPLY: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                    n_ready = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_ready = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b1;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
        end
    end

    assign o_s_tready    = r_ready;
    assign o_cmd.capture = i_s_tvalid && r_ready;
    assign o_cmd.calc    = (r_state == S_CALC);
    assign o_cmd.apply   = (r_state == S_APPLY) && i_sts.out_free;

endmodule

// File: design/qds_datapath.sv
// qds_datapath: arrival time ring buffer, queue state, accumulators and
// output register; depends on qds_pkg
module qds_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  qds_pkg::t_cmd                   i_cmd,
    output qds_pkg::t_sts                   o_sts,
    input  logic [qds_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                            i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [qds_pkg::OUT_TDATA_W-1:0] o_m_tdata
);
    import qds_pkg::*;

    logic [TIME_BITS-1:0] mem [QUEUE_DEPTH];

    // control state
    logic [ADDR_W-1:0]    r_head;
    logic [CNT_W-1:0]     r_count;
    logic                 r_busy;
    logic [SERVED_W-1:0]  r_served;
    logic [ACC_W-1:0]     r_delay_sum;
    logic [ACC_W-1:0]     r_area_q;
    logic [ACC_W-1:0]     r_area_b;
    logic [TIME_BITS-1:0] r_prev;
    logic                 r_out_valid;

    // payload
    t_op                  r_op;
    logic [TIME_BITS-1:0] r_time;
    logic [TIME_BITS-1:0] r_mem_q;
    logic                 r_back;
    logic [TIME_BITS-1:0] r_eff;
    logic [TIME_BITS-1:0] r_elapsed;
    logic [TIME_BITS-1:0] r_wait;
    logic [PROD_W-1:0]    r_prod;
    logic [OUT_TDATA_W-1:0] r_tdata;

    // calc stage
    logic                 calc_back;
    logic [TIME_BITS-1:0] calc_eff;
    logic [TIME_BITS-1:0] calc_elapsed;

    // apply stage
    logic [ADDR_W-1:0]    n_head;
    logic [CNT_W-1:0]     n_count;
    logic                 n_busy;
    logic [SERVED_W-1:0]  n_served;
    logic [ACC_W-1:0]     n_delay_sum;
    logic [ACC_W-1:0]     n_area_q;
    logic [ACC_W-1:0]     n_area_b;
    logic [DELAY_W-1:0]   n_delay;
    t_status              n_status;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [ADDR_W:0]      slot_sum;
    logic [SUM_W-1:0]     sum_q;
    logic [ACC_W:0]       sum_b;
    logic [ACC_W:0]       sum_d;
    logic [ACC_W-1:0]     wait_ext;
    logic                 start;
    logic [TIME_BITS-1:0] start_wait;
    logic [OUT_FIELD_W-1:0] n_fields;

    always_comb begin
        calc_back    = (r_time < r_prev);
        calc_eff     = calc_back ? r_prev : r_time;
        calc_elapsed = calc_back ? '0 : (r_time - r_prev);
    end

    always_comb begin
        n_head      = r_head;
        n_count     = r_count;
        n_busy      = r_busy;
        n_served    = r_served;
        n_delay_sum = r_delay_sum;
        n_delay     = '0;
        n_status    = r_back ? ST_BACKWARD : ST_OK;
        mem_we      = 1'b0;
        start       = 1'b0;
        start_wait  = '0;

        slot_sum = (ADDR_W + 1)'(r_head) + (ADDR_W + 1)'(r_count);
        if (slot_sum >= (ADDR_W + 1)'(QUEUE_DEPTH)) begin
            slot_sum = slot_sum - (ADDR_W + 1)'(QUEUE_DEPTH);
        end
        mem_waddr = slot_sum[ADDR_W-1:0];

        sum_q = SUM_W'(r_area_q) + SUM_W'(r_prod);
        if (sum_q > SUM_W'({ACC_W{1'b1}})) begin
            n_area_q = '1;
        end else begin
            n_area_q = sum_q[ACC_W-1:0];
        end

        sum_b    = (ACC_W + 1)'(r_area_b) + (ACC_W + 1)'(r_elapsed);
        n_area_b = r_area_b;
        if (r_busy) begin
            n_area_b = sum_b[ACC_W] ? '1 : sum_b[ACC_W-1:0];
        end

        if (r_op == OP_ARRIVE) begin
            if (r_busy) begin
                if (r_count >= CNT_W'(QUEUE_DEPTH)) begin
                    n_status = ST_OVERFLOW;
                end else begin
                    mem_we  = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end else begin
                n_busy = 1'b1;
                start  = 1'b1;
            end
        end else begin
            if (r_count == '0) begin
                n_busy = 1'b0;
            end else begin
                n_head     = (r_head == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : (r_head + 1'b1);
                n_count    = r_count - 1'b1;
                n_busy     = 1'b1;
                start      = 1'b1;
                start_wait = r_wait;
            end
        end

        wait_ext = ACC_W'(start_wait);
        sum_d    = (ACC_W + 1)'(r_delay_sum) + (ACC_W + 1)'(wait_ext);
        if (start) begin
            if (r_served != '1) begin
                n_served = r_served + 1'b1;
            end
            n_delay_sum = sum_d[ACC_W] ? '1 : sum_d[ACC_W-1:0];
            n_delay     = (wait_ext > ACC_W'({DELAY_W{1'b1}})) ? '1
                                                                : wait_ext[DELAY_W-1:0];
        end

        n_fields = {n_status, n_area_b, n_area_q, n_delay_sum, n_delay, n_served,
                    n_busy, QLEN_W'(n_count)};
    end

    // ring buffer
    always_ff @(posedge i_clk) begin
        if (i_cmd.apply && mem_we) begin
            mem[mem_waddr] <= r_eff;
        end
        r_mem_q <= mem[r_head];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= t_op'(i_s_tuser);
            r_time <= TIME_BITS'(i_s_tdata[EVT_TIME_W-1:0]);
        end
        if (i_cmd.calc) begin
            r_back    <= calc_back;
            r_eff     <= calc_eff;
            r_elapsed <= calc_elapsed;
            r_prod    <= PROD_W'(r_count) * PROD_W'(calc_elapsed);
            r_wait    <= (calc_eff >= r_mem_q) ? (calc_eff - r_mem_q) : '0;
        end
        if (i_cmd.apply) begin
            r_tdata <= OUT_TDATA_W'(n_fields);
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_busy      <= 1'b0;
            r_served    <= '0;
            r_delay_sum <= '0;
            r_area_q    <= '0;
            r_area_b    <= '0;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.apply) begin
                r_head      <= n_head;
                r_count     <= n_count;
                r_busy      <= n_busy;
                r_served    <= n_served;
                r_delay_sum <= n_delay_sum;
                r_area_q    <= n_area_q;
                r_area_b    <= n_area_b;
                r_prev      <= r_eff;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.out_free = !r_out_valid || i_m_tready;
    assign o_m_tvalid     = r_out_valid;
    assign o_m_tdata      = r_tdata;

endmodule

// File: design/queue_delay_statistics_top.sv
// Single-server queue monitor. Each input beat is one event, an arrival
// (tuser 0) or a departure (tuser 1) stamped with its time in ticks, and it
// gives one output beat with the queue length, busy flag, served count, the
// wait of the customer starting service, the summed waits, and the time-areas
// of queue length and busy, all saturating. The accepting edge captures the
// event with the ring buffer read of the queue head, the calc state then
// registers the elapsed time, the queue-length product and the wait, and the
// apply state then updates state and the output register. One event is in
// work at a time, so the block takes no new event until the last one has
// updated state; the result sits in an output register, so the next event
// is taken while it waits, and the update stalls only when the previous
// result is still untaken.
// depends on qds_pkg, qds_ctrl, qds_datapath
module queue_delay_statistics_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [qds_pkg::IN_TDATA_W-1:0]  i_s_tdata,  // event_time
    input  logic                            i_s_tuser,  // operation
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // queue_length, server_busy, customers_served, event_delay, total_delay,
    // area_queue, area_busy, status, zero pad
    output logic [qds_pkg::OUT_TDATA_W-1:0] o_m_tdata
);
    import qds_pkg::*;

    t_cmd cmd;
    t_sts sts;

    qds_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    qds_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

// File: verif/tb_queue_delay_statistics_top.sv
// Testbench for queue_delay_statistics_top: drives arrive and depart events on the input stream
// and checks every output beat against a cycle-free predictor of the queue statistics.
// Depends on qds_pkg and the queue_delay_statistics_top design.
`timescale 1ns / 100ps

module tb_queue_delay_statistics_top;
    import qds_pkg::*;

    localparam int HOLD_CYCLES = 200;

    typedef struct packed {
        logic [OUT_TDATA_W-OUT_FIELD_W-1:0] pad;
        t_status                            status;
        logic [ACC_W-1:0]                   area_busy, area_queue, total_delay;
        logic [DELAY_W-1:0]                 event_delay;
        logic [SERVED_W-1:0]                served;
        logic                               busy;
        logic [QLEN_W-1:0]                  qlen;
    } t_queue_stats;

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata  = '0;
    logic                   i_s_tuser  = 1'b0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;

    queue_delay_statistics_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #2 i_clk = ~i_clk;

    // predicted queue state
    logic [EVT_TIME_W-1:0] arrival_ring [QUEUE_DEPTH];
    logic [ADDR_W-1:0]     head_slot   = '0;
    logic [CNT_W-1:0]      waiting     = '0;
    logic                  busy_now    = 1'b0;
    logic [SERVED_W-1:0]   served      = '0;
    logic [ACC_W-1:0]      delay_sum   = '0;
    logic [ACC_W-1:0]      queue_area  = '0;
    logic [ACC_W-1:0]      busy_area   = '0;
    logic [EVT_TIME_W-1:0] last_time   = '0;

    t_queue_stats expected_stats [$];
    int           mismatch_count = 0;
    bit           steady         = 1'b0;
    int           hold_requests  = 0;
    int           hold_seen      = 0;
    int           hold_left      = 0;

    function automatic logic [ACC_W-1:0] sat48(input logic [ACC_W:0] s);
        return s[ACC_W] ? '1 : s[ACC_W-1:0];
    endfunction

    task automatic start_service(input logic [EVT_TIME_W-1:0] wait_ticks,
                                 output logic [DELAY_W-1:0] delay);
        if (served != '1)
            served++;
        delay_sum = sat48({1'b0, delay_sum} + (ACC_W+1)'(wait_ticks));
        delay = wait_ticks;
    endtask

    task automatic predict_queue_event(input t_op op, input logic [EVT_TIME_W-1:0] t_in);
        t_queue_stats          r;
        logic [EVT_TIME_W-1:0] t_eff;
        logic [EVT_TIME_W-1:0] elapsed;
        logic [EVT_TIME_W-1:0] wait_ticks;
        logic [ADDR_W-1:0]     slot;
        r = '0;
        r.status = ST_OK;
        elapsed = '0;
        if (t_in < last_time) begin
            t_eff = last_time;
            r.status = ST_BACKWARD;
        end else begin
            elapsed = t_in - last_time;
            t_eff = t_in;
            last_time = t_in;
        end
        queue_area = sat48({1'b0, queue_area} + (ACC_W+1)'(waiting) * (ACC_W+1)'(elapsed));
        if (busy_now)
            busy_area = sat48({1'b0, busy_area} + (ACC_W+1)'(elapsed));
        if (op == OP_ARRIVE) begin
            if (busy_now) begin
                if (waiting >= QUEUE_DEPTH) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    slot = head_slot + waiting[ADDR_W-1:0];
                    arrival_ring[slot] = t_eff;
                    waiting++;
                end
            end else begin
                busy_now = 1'b1;
                start_service('0, r.event_delay);
            end
        end else begin
            if (waiting == 0) begin
                busy_now = 1'b0;
            end else begin
                wait_ticks = (t_eff >= arrival_ring[head_slot]) ?
                             t_eff - arrival_ring[head_slot] : '0;
                head_slot++;
                waiting--;
                busy_now = 1'b1;
                start_service(wait_ticks, r.event_delay);
            end
        end
        r.qlen        = QLEN_W'(waiting);
        r.busy        = busy_now;
        r.served      = served;
        r.total_delay = delay_sum;
        r.area_queue  = queue_area;
        r.area_busy   = busy_area;
        expected_stats.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    task automatic check_result(input t_queue_stats got);
        t_queue_stats want;
        if (expected_stats.size() == 0) begin
            report_mismatch("beat with nothing pending", got.qlen, 0);
            return;
        end
        want = expected_stats.pop_front();
        check_field("queue_length", got.qlen, want.qlen);
        check_field("server_busy", got.busy, want.busy);
        check_field("customers_served", got.served, want.served);
        check_field("event_delay", got.event_delay, want.event_delay);
        check_field("total_delay", got.total_delay, want.total_delay);
        check_field("area_queue", got.area_queue, want.area_queue);
        check_field("area_busy", got.area_busy, want.area_busy);
        check_field("status", got.status, want.status);
        check_field("pad", got.pad, want.pad);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            check_result(o_m_tdata);
    end

    // receiver: random idling, long hold-off on request
    always @(posedge i_clk) begin
        if (hold_requests != hold_seen) begin
            hold_seen <= hold_requests;
            hold_left <= HOLD_CYCLES;
            i_m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else if (!steady && $urandom_range(0, 99) < 9) begin
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    task automatic send_event(input t_op op, input logic [EVT_TIME_W-1:0] t);
        int gap;
        if (!steady && $urandom_range(0, 99) < 9) begin
            gap = $urandom_range(1, 4);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= t;
        i_s_tuser  <= op;
        do @(posedge i_clk); while (!o_s_tready);
        predict_queue_event(op, t);
    endtask

    task automatic wait_for_results();
        i_s_tvalid <= 1'b0;
        while (expected_stats.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [EVT_TIME_W-1:0] next_time();
        int                    r;
        logic [EVT_TIME_W-1:0] inc;
        r = $urandom_range(0, 99);
        if (r < 5 && last_time != 0)
            return $urandom_range(last_time - 1, 0);
        if (r < 80)
            inc = $urandom_range(0, 40);
        else if (r < 97)
            inc = $urandom_range(0, 5000);
        else
            inc = $urandom_range(0, 1 << 22);
        return last_time + inc;
    endfunction

    task automatic test_basic_events();
        send_event(OP_DEPART, 0);       // idle server, empty queue
        send_event(OP_ARRIVE, 0);
        send_event(OP_ARRIVE, 4);
        send_event(OP_ARRIVE, 4);
        send_event(OP_DEPART, 10);
        send_event(OP_ARRIVE, 2);       // timestamp goes backwards
        send_event(OP_DEPART, 15);
        send_event(OP_DEPART, 15);
        send_event(OP_DEPART, 20);
        send_event(OP_DEPART, 25);
        send_event(OP_ARRIVE, 30);
        send_event(OP_DEPART, 30);
        send_event(OP_DEPART, 1);
        send_event(OP_ARRIVE, 31);
        send_event(OP_DEPART, 40);
    endtask

    task automatic test_queue_full();
        while (!busy_now)
            send_event(OP_ARRIVE, last_time + 1);
        while (waiting < QUEUE_DEPTH)
            send_event(OP_ARRIVE, last_time + $urandom_range(0, 3));
        send_event(OP_ARRIVE, last_time + 2);
        send_event(OP_ARRIVE, last_time - 1);   // full queue and backwards together
        send_event(OP_DEPART, last_time + 1000000);
        while (waiting != 0)
            send_event(OP_DEPART, last_time + $urandom_range(0, 3));
        send_event(OP_DEPART, last_time + 5);
        send_event(OP_DEPART, last_time + 5);
    endtask

    task automatic test_receiver_stall();
        steady = 1'b1;
        hold_requests++;
        for (int n = 0; n < 12; n++)
            send_event(t_op'($urandom_range(0, 1)), last_time + $urandom_range(0, 20));
        steady = 1'b0;
    endtask

    task automatic test_random_traffic();
        int  arrive_pct;
        t_op op;
        arrive_pct = 50;
        for (int n = 0; n < 250; n++) begin
            if (n % 40 == 0)
                arrive_pct = 30 + 20 * $urandom_range(0, 2);
            steady = (n >= 100 && n < 180);
            op = ($urandom_range(0, 99) < arrive_pct) ? OP_ARRIVE : OP_DEPART;
            send_event(op, next_time());
        end
        steady = 1'b0;
    endtask

    task automatic test_time_limit();
        send_event(OP_ARRIVE, 32'hFFFF_FFFF);
        for (int n = 0; n < 12; n++)
            send_event(t_op'($urandom_range(0, 1)), $urandom);
        send_event(OP_DEPART, 32'hFFFF_FFFF);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_basic_events();
        wait_for_results();
        test_queue_full();
        wait_for_results();
        test_receiver_stall();
        wait_for_results();
        test_random_traffic();
        wait_for_results();
        test_time_limit();
        wait_for_results();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
